// File: src/tai_pkg.sv
`default_nettype none

package tai_pkg;

	// Event kinds reported by the core
	localparam logic [1:0] KIND_RETIRE = 2'd0;
	localparam logic [1:0] KIND_EXC    = 2'd1;
	localparam logic [1:0] KIND_RET    = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// Privilege levels
	localparam logic [1:0] LVL_U = 2'd0;
	localparam logic [1:0] LVL_S = 2'd1;
	localparam logic [1:0] LVL_R = 2'd2;
	localparam logic [1:0] LVL_M = 2'd3;

	// Slot of each level in the per-level save registers and enable bits
	localparam logic [1:0] IDX_U = 2'd0;
	localparam logic [1:0] IDX_S = 2'd1;
	localparam logic [1:0] IDX_M = 2'd2;

	// Handler mode held in the low bits of a vector register
	localparam logic [1:0] MODE_VECTORED = 2'd1;

	// Configuration register indexes
	localparam logic [2:0] CFG_MVEC    = 3'd0;
	localparam logic [2:0] CFG_SVEC    = 3'd1;
	localparam logic [2:0] CFG_UVEC    = 3'd2;
	localparam logic [2:0] CFG_MEXCDEL = 3'd3;
	localparam logic [2:0] CFG_MINTDEL = 3'd4;
	localparam logic [2:0] CFG_SEXCDEL = 3'd5;
	localparam logic [2:0] CFG_SINTDEL = 3'd6;
	localparam logic [2:0] CFG_INTEN   = 3'd7;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] instr_pc;
		logic [31:0] next_pc;
		logic [3:0]  exc_code;
		logic [31:0] trap_value;
		logic [1:0]  return_level;
		logic [11:0] pending_lines;
		logic [9:0]  status_value;
	} tai_in_t;

	typedef struct packed {
		logic [31:0] new_pc;
		logic [1:0]  new_priv;
		logic        trap_taken;
		logic        is_interrupt;
		logic [3:0]  cause_code;
		logic [9:0]  status_out;
	} tai_out_t;

	typedef struct packed {
		logic [31:0] machine_vector;
		logic [31:0] super_vector;
		logic [31:0] user_vector;
		logic [15:0] m_exc_delegate;
		logic [11:0] m_int_delegate;
		logic [15:0] s_exc_delegate;
		logic [11:0] s_int_delegate;
		logic [11:0] int_enable_mask;
	} tai_cfg_t;

	// Architectural trap state, one save slot per level (user, super, machine)
	typedef struct packed {
		logic [1:0]       priv;
		logic [2:0]       ie;
		logic [2:0]       pie;
		logic [1:0]       mpp;
		logic             spp;
		logic [2:0][31:0] epc;
		logic [2:0][4:0]  cause;
		logic [2:0][31:0] tval;
	} tai_state_t;

endpackage

`default_nettype wire

// File: src/tai_core.sv
`default_nettype none

// Next-state and result logic for one transaction
module tai_core #(
	parameter bit HAS_USER_MODE = 1'b1
) (
	input  tai_pkg::tai_state_t st,
	input  tai_pkg::tai_cfg_t   cfg,
	input  tai_pkg::tai_in_t    item,
	output tai_pkg::tai_state_t nxt,
	output tai_pkg::tai_out_t   res
);
	import tai_pkg::*;

	localparam logic [1:0] MPP_CLEAR = HAS_USER_MODE ? LVL_U : LVL_M;
	localparam logic       SPP_CLEAR = HAS_USER_MODE ? 1'b0 : 1'b1;

	// Fixed priority MEI, MSI, MTI, SEI, SSI, STI, UEI, USI, UTI
	function automatic logic [3:0] prio_code(input logic [11:0] set);
		logic [3:0] c;
		if (set[11])     c = 4'd11;
		else if (set[3]) c = 4'd3;
		else if (set[7]) c = 4'd7;
		else if (set[9]) c = 4'd9;
		else if (set[1]) c = 4'd1;
		else if (set[5]) c = 4'd5;
		else if (set[8]) c = 4'd8;
		else if (set[0]) c = 4'd0;
		else if (set[4]) c = 4'd4;
		else             c = 4'd0;
		return c;
	endfunction

	function automatic logic [1:0] lvl_idx(input logic [1:0] lvl);
		logic [1:0] i;
		if (lvl == LVL_M)      i = IDX_M;
		else if (lvl == LVL_S) i = IDX_S;
		else                   i = IDX_U;
		return i;
	endfunction

	tai_state_t  mid;
	logic [31:0] pc;
	logic        enter;
	logic        irq;
	logic [3:0]  code;
	logic [1:0]  target;
	logic [1:0]  idx;
	logic [1:0]  prior;
	logic [31:0] vec;
	logic [31:0] epc_val;
	logic [11:0] pend;
	logic [11:0] pend_del;
	logic [11:0] m_set;
	logic [11:0] s_set;
	logic [11:0] u_set;
	logic [1:0]  mpp_wr;

	always_comb begin
		mid     = st;
		pc      = item.next_pc;
		enter   = 1'b0;
		irq     = 1'b0;
		code    = 4'd0;
		target  = LVL_M;
		epc_val = item.next_pc;
		mpp_wr  = item.status_value[7:6];
		if (mpp_wr == LVL_R) begin
			mpp_wr = MPP_CLEAR;
		end

		// Returns and status writes update state before interrupt selection
		case (item.kind)
			KIND_RET: begin
				case (item.return_level)
					LVL_M: begin
						mid.priv   = st.mpp;
						mid.ie[2]  = st.pie[2];
						mid.pie[2] = 1'b1;
						mid.mpp    = MPP_CLEAR;
						pc         = st.epc[IDX_M];
					end
					LVL_S: begin
						mid.priv   = {1'b0, st.spp};
						mid.ie[1]  = st.pie[1];
						mid.pie[1] = 1'b1;
						mid.spp    = SPP_CLEAR;
						pc         = st.epc[IDX_S];
					end
					LVL_U: begin
						mid.priv   = LVL_U;
						mid.ie[0]  = st.pie[0];
						mid.pie[0] = 1'b1;
						pc         = st.epc[IDX_U];
					end
					default: begin
					end
				endcase
			end
			KIND_STATUS: begin
				mid.ie  = item.status_value[2:0];
				mid.pie = item.status_value[5:3];
				mid.mpp = mpp_wr;
				mid.spp = item.status_value[8];
			end
			default: begin
			end
		endcase

		// Interrupt filtering by enable, delegation and global enables
		pend     = item.pending_lines & cfg.int_enable_mask;
		m_set    = pend & ~cfg.m_int_delegate;
		pend_del = pend & cfg.m_int_delegate;
		s_set    = pend_del & ~cfg.s_int_delegate;
		u_set    = pend_del & cfg.s_int_delegate;

		if (item.kind == KIND_EXC) begin
			// Synchronous exception with two-stage delegation
			if (st.priv == LVL_M || !cfg.m_exc_delegate[item.exc_code]) begin
				target = LVL_M;
			end else if (st.priv == LVL_S || !cfg.s_exc_delegate[item.exc_code]) begin
				target = LVL_S;
			end else begin
				target = LVL_U;
			end
			enter   = 1'b1;
			code    = item.exc_code;
			epc_val = item.instr_pc;
		end else if (m_set != 12'd0 && (mid.priv != LVL_M || mid.ie[2])) begin
			target  = LVL_M;
			enter   = 1'b1;
			irq     = 1'b1;
			code    = prio_code(m_set);
			epc_val = pc;
		end else if (s_set != 12'd0 &&
			(mid.priv == LVL_U || (mid.priv == LVL_S && mid.ie[1]))) begin
			target  = LVL_S;
			enter   = 1'b1;
			irq     = 1'b1;
			code    = prio_code(s_set);
			epc_val = pc;
		end else if (u_set != 12'd0 && mid.priv == LVL_U && mid.ie[0]) begin
			target  = LVL_U;
			enter   = 1'b1;
			irq     = 1'b1;
			code    = prio_code(u_set);
			epc_val = pc;
		end

		// Handler entry: save context, stack enables, jump to vector
		nxt   = mid;
		idx   = lvl_idx(target);
		prior = mid.priv;
		if (target == LVL_M) begin
			vec = cfg.machine_vector;
		end else if (target == LVL_S) begin
			vec = cfg.super_vector;
		end else begin
			vec = cfg.user_vector;
		end
		if (enter) begin
			nxt.priv       = target;
			nxt.epc[idx]   = epc_val;
			nxt.cause[idx] = {irq, code};
			nxt.pie[idx]   = mid.ie[idx];
			nxt.ie[idx]    = 1'b0;
			if (!irq) begin
				nxt.tval[idx] = item.trap_value;
			end
			if (target == LVL_M) begin
				nxt.mpp = prior;
			end else if (target == LVL_S) begin
				nxt.spp = prior[0];
			end
			pc = {vec[31:2], 2'b00};
			if (irq && vec[1:0] == MODE_VECTORED) begin
				pc = pc + {26'd0, code, 2'b00};
			end
		end

		res.new_pc       = pc;
		res.new_priv     = nxt.priv;
		res.trap_taken   = enter;
		res.is_interrupt = irq;
		res.cause_code   = code;
		res.status_out   = {1'b0, nxt.spp, nxt.mpp, nxt.pie, nxt.ie};
	end

endmodule

`default_nettype wire

// File: src/trap_and_interrupt_unit.sv
// Trap and interrupt unit for a user/supervisor/machine core.
// The core sends one transaction per event (retired instruction, exception,
// trap return, status write) on the in channel (valid/ready, payload in_data)
// and receives one result per transaction on the out channel: next pc,
// privilege, trap flags, cause and packed status.
// Configuration (vectors, delegation masks, interrupt enables) is written
// through cfg_we/cfg_index/cfg_data while no transaction is in flight.
// A transaction is registered in the input stage, evaluated against the
// trap state, and its result is registered in the output register.
// Throughput is one transaction per cycle unless the receiver stalls; the
// state update and result both complete in the single evaluation stage.
// When the receiver stalls, the output register holds its result and one
// further transaction may wait in the input stage; in_ready then drops.
// Reset puts the core at machine level with all enables, stacked state,
// save registers and configuration cleared; both stages come up empty.
`default_nettype none

module trap_and_interrupt_unit #(
	parameter bit HAS_USER_MODE = 1'b1
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  tai_pkg::tai_in_t  in_data,
	output logic              out_valid,
	input  wire               out_ready,
	output tai_pkg::tai_out_t out_data,
	input  wire               cfg_we,
	input  wire [2:0]         cfg_index,
	input  wire [31:0]        cfg_data
);
	import tai_pkg::*;

	// Trap state after reset: machine level, everything else cleared
	localparam tai_state_t STATE_RESET = '{priv: LVL_M, ie: '0, pie: '0, mpp: '0,
		spp: 1'b0, epc: '0, cause: '0, tval: '0};

	tai_cfg_t   cfg_q;
	tai_state_t state_q;
	tai_state_t state_nxt;
	tai_in_t    item_s1;
	logic       valid_s1;
	tai_out_t   res;
	tai_out_t   res_s2;
	logic       valid_s2;
	logic       advance;

	// Output stage moves when empty or being taken
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MVEC:    cfg_q.machine_vector  <= cfg_data;
				CFG_SVEC:    cfg_q.super_vector    <= cfg_data;
				CFG_UVEC:    cfg_q.user_vector     <= cfg_data;
				CFG_MEXCDEL: cfg_q.m_exc_delegate  <= cfg_data[15:0];
				CFG_MINTDEL: cfg_q.m_int_delegate  <= cfg_data[11:0];
				CFG_SEXCDEL: cfg_q.s_exc_delegate  <= cfg_data[15:0];
				CFG_SINTDEL: cfg_q.s_int_delegate  <= cfg_data[11:0];
				CFG_INTEN:   cfg_q.int_enable_mask <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	tai_core #(
		.HAS_USER_MODE(HAS_USER_MODE)
	) u_core (
		.st  (state_q),
		.cfg (cfg_q),
		.item(item_s1),
		.nxt (state_nxt),
		.res (res)
	);

	// Trap state commits as the transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire
